// ===== hw/rtl/vrpm_pkg.sv =====
// Shared definitions for the video register port: memory geometry, bus
// operation codes, address regions and the address decode result.
// No dependencies.
package vrpm_pkg;

  localparam int unsigned ADDRESS_SPACE    = 16384;
  localparam int unsigned NAMETABLE_START  = 8192;
  localparam int unsigned NAMETABLE_MIRROR = 4096;
  localparam int unsigned PALETTE_START    = 16128;
  localparam int unsigned PALETTE_ENTRIES  = 32;

  localparam int unsigned PAT_DEPTH  = 8192;
  localparam int unsigned NAME_DEPTH = 4096;
  localparam int unsigned PAL_DEPTH  = 32;
  localparam int unsigned OAM_DEPTH  = 256;

  localparam int unsigned VADDR_W = 16;
  localparam int unsigned SPACE_W = $clog2(ADDRESS_SPACE);
  localparam int unsigned PAT_AW  = $clog2(PAT_DEPTH);
  localparam int unsigned NAME_AW = $clog2(NAME_DEPTH);
  localparam int unsigned PAL_AW  = $clog2(PAL_DEPTH);
  localparam int unsigned OAM_AW  = $clog2(OAM_DEPTH);
  localparam int unsigned INC_W   = 6;

  typedef enum logic [2:0] {
    OP_STATUS_RD = 3'd0,
    OP_OAM_ADDR  = 3'd1,
    OP_OAM_WR    = 3'd2,
    OP_OAM_RD    = 3'd3,
    OP_SCROLL_WR = 3'd4,
    OP_ADDR_WR   = 3'd5,
    OP_DATA_WR   = 3'd6,
    OP_DATA_RD   = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    REGION_PAT  = 2'd0,
    REGION_NAME = 2'd1,
    REGION_PAL  = 2'd2
  } region_e;

  typedef struct packed {
    region_e             region;
    logic [PAT_AW-1:0]   index;
  } map_t;

endpackage

// ===== hw/rtl/vrpm_ram.sv =====
// Single-port synchronous RAM with registered read data.
// No dependencies.
module vrpm_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/vrpm_map.sv =====
// Video address decoder: folds a 16-bit video address into pattern,
// nametable or palette store and gives the entry index. Uses vrpm_pkg.
module vrpm_map #(
  parameter int unsigned NametableMirror = vrpm_pkg::NAMETABLE_MIRROR
) (
  input  logic [vrpm_pkg::VADDR_W-1:0] vaddr_i,
  output vrpm_pkg::map_t               map_o
);
  import vrpm_pkg::*;

  // The nametable window is shorter than eight mirrors of the smallest size,
  // so a short chain of conditional subtracts folds the offset.
  localparam int unsigned MirrorSteps =
      (PALETTE_START - NAMETABLE_START - 1) / NametableMirror;
  localparam logic [PAT_AW-1:0] Mirror = PAT_AW'(NametableMirror);

  logic [SPACE_W-1:0] space_addr;
  logic [PAT_AW-1:0]  name_off;

  assign space_addr = vaddr_i[SPACE_W-1:0];

  always_comb begin
    name_off = PAT_AW'(space_addr - SPACE_W'(NAMETABLE_START));
    for (int k = 0; k < MirrorSteps; k++) begin
      if (name_off >= Mirror) begin
        name_off = name_off - Mirror;
      end
    end
  end

  always_comb begin
    if (space_addr < SPACE_W'(NAMETABLE_START)) begin
      map_o.region = REGION_PAT;
      map_o.index  = space_addr[PAT_AW-1:0];
    end else if (space_addr < SPACE_W'(PALETTE_START)) begin
      map_o.region = REGION_NAME;
      map_o.index  = name_off;
    end else begin
      map_o.region = REGION_PAL;
      map_o.index  = {{(PAT_AW-PAL_AW){1'b0}},
                      PAL_AW'(space_addr - SPACE_W'(PALETTE_START))};
    end
  end

endmodule

// ===== hw/rtl/video_register_port_vram_map.sv =====
// Top level of the CPU-side video register port with its video memory map.
// Holds the access sequencer, the address and sprite pointers, the palette
// and the sprite, pattern and nametable RAMs. Uses vrpm_pkg, vrpm_map, vrpm_ram.
//
// Every accepted word returns its result word in the next cycle, on done_o,
// and the receiver cannot stall it. One word is taken per cycle while busy_o
// is low, as each RAM port makes a single access per word. After reset the
// block clears the pattern, nametable and sprite RAMs with busy_o high;
// start_i is ignored during that sweep, but increment register writes are taken.
module video_register_port_vram_map #(
  parameter int unsigned NametableMirror = vrpm_pkg::NAMETABLE_MIRROR
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command channel.
  input  logic                        start_i,
  output logic                        busy_o,
  input  vrpm_pkg::opcode_e           opcode_i,
  input  logic [7:0]                  write_data_i,
  input  logic                        sprite_overflow_i,
  input  logic                        sprite_zero_hit_i,
  input  logic                        vblank_flag_i,
  // Increment register.
  input  logic                        vram_increment_we_i,
  input  logic [vrpm_pkg::INC_W-1:0]  vram_increment_i,
  // Result channel.
  output logic                        done_o,
  output logic [7:0]                  read_data_o
);
  import vrpm_pkg::*;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  // Where the result byte comes from in the cycle after acceptance.
  typedef enum logic [1:0] {
    SEL_REG,
    SEL_OAM,
    SEL_PAT,
    SEL_NAME
  } sel_e;

  state_e              state_q, state_d;
  logic [PAT_AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic                done_q, done_d;
  sel_e                sel_q, sel_d;
  logic [7:0]          res_q, res_d;

  logic [INC_W-1:0]    inc_q;
  logic [VADDR_W-1:0]  vaddr_q, vaddr_d;
  logic [7:0]          addr_hi_q, addr_hi_d;
  logic [7:0]          addr_lo_q, addr_lo_d;
  logic                addr_toggle_q, addr_toggle_d;
  logic [OAM_AW-1:0]   oam_ptr_q, oam_ptr_d;
  logic [7:0]          pal_q [PAL_DEPTH];

  logic                clearing;
  logic                accept;
  map_t                vmap;
  logic [PAL_AW-1:0]   pal_idx;
  logic                pal_we;

  logic                pat_we, name_we, oam_we;
  logic [PAT_AW-1:0]   pat_addr;
  logic [NAME_AW-1:0]  name_addr;
  logic [OAM_AW-1:0]   oam_addr;
  logic [7:0]          mem_wdata;
  logic [7:0]          pat_rdata, name_rdata, oam_rdata;

  assign clearing = (state_q == ST_CLEAR);
  assign busy_o   = clearing;
  assign accept   = start_i && !clearing;

  // The video address is decoded every cycle; a data access uses the
  // decode of the address as it stands when the word is accepted.
  vrpm_map #(
    .NametableMirror(NametableMirror)
  ) u_map (
    .vaddr_i(vaddr_q),
    .map_o  (vmap)
  );

  assign pal_idx = vmap.index[PAL_AW-1:0];

  // RAM ports. During the clearing sweep every RAM writes zero at the
  // sweep count; afterwards each RAM sees at most one access per word.
  assign mem_wdata = clearing ? 8'd0 : write_data_i;
  assign pat_addr  = clearing ? clr_cnt_q : vmap.index;
  assign name_addr = clearing ? clr_cnt_q[NAME_AW-1:0] : vmap.index[NAME_AW-1:0];
  assign oam_addr  = clearing ? clr_cnt_q[OAM_AW-1:0] : oam_ptr_q;

  assign pat_we  = clearing ||
                   (accept && opcode_i == OP_DATA_WR && vmap.region == REGION_PAT);
  assign name_we = clearing ||
                   (accept && opcode_i == OP_DATA_WR && vmap.region == REGION_NAME);
  assign oam_we  = clearing || (accept && opcode_i == OP_OAM_WR);
  assign pal_we  = accept && opcode_i == OP_DATA_WR && vmap.region == REGION_PAL;

  vrpm_ram #(
    .Depth(PAT_DEPTH),
    .Width(8)
  ) u_pat_ram (
    .clk_i  (clk_i),
    .addr_i (pat_addr),
    .we_i   (pat_we),
    .wdata_i(mem_wdata),
    .rdata_o(pat_rdata)
  );

  vrpm_ram #(
    .Depth(NAME_DEPTH),
    .Width(8)
  ) u_name_ram (
    .clk_i  (clk_i),
    .addr_i (name_addr),
    .we_i   (name_we),
    .wdata_i(mem_wdata),
    .rdata_o(name_rdata)
  );

  vrpm_ram #(
    .Depth(OAM_DEPTH),
    .Width(8)
  ) u_oam_ram (
    .clk_i  (clk_i),
    .addr_i (oam_addr),
    .we_i   (oam_we),
    .wdata_i(mem_wdata),
    .rdata_o(oam_rdata)
  );

  // Pointer and latch updates. There is no scroll latch in this block, so a
  // scroll write only returns its zero result word.
  always_comb begin
    vaddr_d       = vaddr_q;
    addr_hi_d     = addr_hi_q;
    addr_lo_d     = addr_lo_q;
    addr_toggle_d = addr_toggle_q;
    oam_ptr_d     = oam_ptr_q;
    if (accept) begin
      case (opcode_i)
        OP_OAM_ADDR: begin
          oam_ptr_d = write_data_i;
        end
        OP_OAM_WR: begin
          oam_ptr_d = oam_ptr_q + OAM_AW'(1);
        end
        OP_ADDR_WR: begin
          // The toggle resets high, so the first write after reset lands in
          // the high byte.
          addr_toggle_d = !addr_toggle_q;
          if (addr_toggle_q) begin
            addr_hi_d = write_data_i;
          end else begin
            addr_lo_d = write_data_i;
          end
          vaddr_d = {addr_hi_d, addr_lo_d};
        end
        OP_DATA_WR, OP_DATA_RD: begin
          vaddr_d = vaddr_q + VADDR_W'(inc_q);
        end
        default: begin
        end
      endcase
    end
  end

  // Result word selection, registered for the cycle after acceptance.
  always_comb begin
    done_d = accept;
    sel_d  = SEL_REG;
    res_d  = 8'd0;
    case (opcode_i)
      OP_STATUS_RD: begin
        res_d = {vblank_flag_i, sprite_zero_hit_i, sprite_overflow_i, 5'd0};
      end
      OP_OAM_RD: begin
        sel_d = SEL_OAM;
      end
      OP_DATA_RD: begin
        case (vmap.region)
          REGION_PAT:  sel_d = SEL_PAT;
          REGION_NAME: sel_d = SEL_NAME;
          default:     res_d = pal_q[pal_idx];
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    if (clearing) begin
      clr_cnt_d = clr_cnt_q + PAT_AW'(1);
      if (clr_cnt_q == PAT_AW'(PAT_DEPTH - 1)) begin
        state_d = ST_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
      sel_q     <= SEL_REG;
      res_q     <= 8'd0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
      sel_q     <= sel_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q         <= INC_W'(1);
      vaddr_q       <= '0;
      addr_hi_q     <= 8'd0;
      addr_lo_q     <= 8'd0;
      addr_toggle_q <= 1'b1;
      oam_ptr_q     <= '0;
    end else begin
      if (vram_increment_we_i) begin
        inc_q <= vram_increment_i;
      end
      vaddr_q       <= vaddr_d;
      addr_hi_q     <= addr_hi_d;
      addr_lo_q     <= addr_lo_d;
      addr_toggle_q <= addr_toggle_d;
      oam_ptr_q     <= oam_ptr_d;
    end
  end

  // Palette entries live in flip-flops. A write at a multiple of four also
  // lands in the entry sixteen away, so backdrop colors stay shared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAL_DEPTH; i++) begin
        pal_q[i] <= 8'd0;
      end
    end else if (pal_we) begin
      pal_q[pal_idx] <= write_data_i;
      if (pal_idx[1:0] == 2'b00) begin
        pal_q[pal_idx ^ PAL_AW'(16)] <= write_data_i;
      end
    end
  end

  assign done_o = done_q;

  always_comb begin
    case (sel_q)
      SEL_OAM:  read_data_o = oam_rdata;
      SEL_PAT:  read_data_o = pat_rdata;
      SEL_NAME: read_data_o = name_rdata;
      default:  read_data_o = res_q;
    endcase
  end

  // Every accepted word gives exactly one result word in the next cycle.
  a_done_follows_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni) accept |=> done_o
  ) else $error("accepted word gave no result word");

  a_no_spurious_done: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !accept |=> !done_o
  ) else $error("result word without an accepted word");

  // The sweep writes zero into every RAM on every cycle of the clear.
  a_clear_writes_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      clearing |-> (pat_we && name_we && oam_we && mem_wdata == 8'd0)
  ) else $error("clearing sweep skipped a RAM write");

  // Write operations return zero.
  a_write_returns_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      accept && (opcode_i == OP_OAM_ADDR || opcode_i == OP_OAM_WR ||
                 opcode_i == OP_SCROLL_WR || opcode_i == OP_ADDR_WR ||
                 opcode_i == OP_DATA_WR) |=> read_data_o == 8'd0
  ) else $error("write operation returned nonzero data");

  // After an address write the video address equals the two latched bytes.
  a_addr_latch: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      accept && opcode_i == OP_ADDR_WR |=> vaddr_q == {addr_hi_q, addr_lo_q}
  ) else $error("video address does not match the address latch");

endmodule
